// ===== rtl/ttacl_pkg.sv =====
`timescale 1ns / 1ps

package ttacl_pkg;

    // Field and register widths
    localparam int INCL_W      = 16;
    localparam int ANGLE_W     = 16;
    localparam int ARM_W       = 20;
    localparam int BASE_W      = 17;
    localparam int REST_W      = 20;
    localparam int LEN_W       = 21;
    localparam int SPOOL_W     = 22;
    localparam int NUM_TENDONS = 3;

    localparam int IN_TDATA_W    = 32;
    localparam int OUT_PAYLOAD_W = NUM_TENDONS * (LEN_W + SPOOL_W);
    localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_PAYLOAD_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 2'd2;

    localparam logic [ARM_W-1:0]  ARM_LENGTH_RST  = 20'd200000;
    localparam logic [BASE_W-1:0] BASE_OFFSET_RST = 17'd35000;
    localparam logic [REST_W-1:0] REST_LENGTH_RST = 20'd200000;

    // Angles in hundredths of a degree
    localparam int TURN_CD      = 36000;
    localparam int HALF_TURN_CD = TURN_CD / 2;
    localparam int TENDON_OFFSET_CD [NUM_TENDONS] = '{9000, 21000, 33000};

    // Cosine table: quarter wave, DEPTH+1 entries, Q0.15 magnitudes
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int COS_STEPS       = 4 * COS_TABLE_DEPTH;
    localparam int IDX_W           = $clog2(COS_STEPS);
    localparam int Q_W             = $clog2(COS_STEPS + 1);
    localparam int R_W             = $clog2(COS_TABLE_DEPTH);
    localparam int ADDR_W          = $clog2(COS_TABLE_DEPTH + 1);
    localparam int COS_W           = 15;

    // Phase to table step: floor((phase*STEPS + TURN/2) / TURN)
    localparam longint PH_NUM_MAX = longint'(TURN_CD - 1) * longint'(COS_STEPS)
                                    + longint'(HALF_TURN_CD);
    localparam int     NUM_W      = $clog2(PH_NUM_MAX + 1);
    localparam longint PH_RECIP   = (longint'(1) <<< NUM_W) / TURN_CD;
    localparam int     PH_PROD_W  = NUM_W + Q_W;

    // Bend term: round(mag * PI_Q30 / (SCALE_DIV * 2^30)),
    // SCALE_DIV = 18000 * 2^15 = SCALE_ODD * 2^SCALE_POW
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam int PI_W        = 32;
    localparam int SCALE_ODD   = 1125;
    localparam int SCALE_POW   = 19;
    localparam int BEND_SHIFT  = SCALE_POW + 30;

    localparam int IB_W       = INCL_W + BASE_W;
    localparam int MAG_W      = IB_W + COS_W;
    localparam int SPLIT      = MAG_W / 2;
    localparam int HI_W       = MAG_W - SPLIT;
    localparam int PART_W     = HI_W + PI_W;
    localparam int T_W        = 80;
    localparam int U_W        = T_W - BEND_SHIFT;
    localparam int BEND_W     = 21;
    localparam int BPROD_W    = U_W + BEND_W;
    localparam longint BEND_RECIP = (longint'(1) <<< U_W) / SCALE_ODD;
    localparam logic [T_W-1:0] BEND_RND = T_W'(SCALE_ODD) << (BEND_SHIFT - 1);

    localparam int LEN_CALC_W = LEN_W + 2;

    // Pipeline stages
    localparam int ST_IN       = 0;
    localparam int ST_NUM      = 1;
    localparam int ST_QEST     = 2;
    localparam int ST_IDX      = 3;
    localparam int ST_COS      = 4;
    localparam int ST_MAG      = 5;
    localparam int ST_PART     = 6;
    localparam int ST_SUM      = 7;
    localparam int ST_BEST     = 8;
    localparam int ST_BEND     = 9;
    localparam int ST_OUT      = 10;
    localparam int NUM_STAGES  = 11;

    typedef struct packed {
        logic [NUM_STAGES-1:0] adv;
    } t_pipe_ctl;

    typedef logic [COS_W-1:0] t_cos_rom [0:COS_TABLE_DEPTH];

    // Quarter-wave cosine table, built at elaboration with a Q30 Taylor series
    // of thirteen terms; term n is divided by (2n-1)*(2n)
    function automatic t_cos_rom build_cos_rom();
        t_cos_rom          rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   e;
        longint            sum;
        int                k;
        for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (longint'(k) * HALF_PI_Q30) / COS_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = ONE_Q30;
            sum  = longint'(ONE_Q30);
            term = ((term * x2) >> 30) / 64'd2;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd12;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd30;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd56;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd90;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd132;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd182;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd240;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd306;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd380;
            sum  = sum + longint'(term);
            term = ((term * x2) >> 30) / 64'd462;
            sum  = sum - longint'(term);
            term = ((term * x2) >> 30) / 64'd552;
            sum  = sum + longint'(term);
            if (sum < 0) begin
                sum = 0;
            end
            e = ((longint'(sum) * 64'd32768) + (ONE_Q30 >> 1)) >> 30;
            if (e > 64'd32767) begin
                e = 64'd32767;
            end
            rom[k] = COS_W'(e);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/ttacl_pipe_ctrl.sv =====
`timescale 1ns / 1ps

module ttacl_pipe_ctrl
    import ttacl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_pipe_ctl o_ctl
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] shifted;

    // A stage moves when it is empty or the stage after it moves
    always_comb begin
        adv[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign shifted = {r_valid[NUM_STAGES-2:0], i_in_valid};
    assign n_valid = (adv & shifted) | (~adv & r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = adv[ST_IN];
    assign o_out_valid = r_valid[ST_OUT];
    assign o_ctl.adv   = adv;

endmodule

// ===== rtl/ttacl_cos_rom.sv =====
`timescale 1ns / 1ps

module ttacl_cos_rom
    import ttacl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ADDR_W-1:0] i_addr,
    output logic [COS_W-1:0]  o_data
);

    localparam t_cos_rom COS_ROM = build_cos_rom();

    logic [COS_W-1:0] r_data;

    // Registered table read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= COS_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/ttacl_lane.sv =====
`timescale 1ns / 1ps

module ttacl_lane
    import ttacl_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  logic [ANGLE_W-1:0] i_offset_cd,
    input  logic [ANGLE_W-1:0] i_orient,
    input  logic               i_incl_neg,
    input  logic [IB_W-1:0]    i_ib_prod,
    input  logic [ARM_W-1:0]   i_arm_length,
    input  logic [REST_W-1:0]  i_rest_length,
    output logic [LEN_W-1:0]   o_length,
    output logic [SPOOL_W-1:0] o_spool
);

    logic [ANGLE_W:0]      phase_sum;
    logic [ANGLE_W-1:0]    phase;
    logic [NUM_W-1:0]      n_num;
    logic [NUM_W-1:0]      r_num;
    logic [NUM_W-1:0]      r_num_d;
    logic [PH_PROD_W-1:0]  ph_prod;
    logic [Q_W-1:0]        r_q0;
    logic [NUM_W-1:0]      ph_rem;
    logic [Q_W-1:0]        q_fix;
    logic [IDX_W-1:0]      n_idx;
    logic [IDX_W-1:0]      r_idx;
    logic [1:0]            quad;
    logic [IDX_W-1:0]      quad_base;
    logic [R_W-1:0]        step_in_quad;
    logic [ADDR_W-1:0]     rom_addr;
    logic                  n_cos_neg;
    logic                  r_cos_neg;
    logic [COS_W-1:0]      cos_mag;
    logic [MAG_W-1:0]      r_mag;
    logic                  r_sign [ST_MAG:ST_BEND];
    logic [PART_W-1:0]     r_part_lo;
    logic [PART_W-1:0]     r_part_hi;
    logic [T_W-1:0]        bend_sum;
    logic [U_W-1:0]        r_u;
    logic [U_W-1:0]        r_u_d;
    logic [BPROD_W-1:0]    bend_prod;
    logic [BEND_W-1:0]     r_q0b;
    logic [U_W-1:0]        bend_rem;
    logic [BEND_W-1:0]     n_bend;
    logic [BEND_W-1:0]     r_bend;
    logic [LEN_CALC_W-1:0] len_calc;
    logic [LEN_W-1:0]      n_length;
    logic [LEN_W-1:0]      r_length;
    logic [SPOOL_W-1:0]    r_spool;

    // Phase of this tendon and the scaled numerator for the step index
    always_comb begin
        phase_sum = (ANGLE_W+1)'(i_offset_cd) + (ANGLE_W+1)'(TURN_CD)
                  - (ANGLE_W+1)'(i_orient);
        if (phase_sum >= (ANGLE_W+1)'(TURN_CD)) begin
            phase = ANGLE_W'(phase_sum - (ANGLE_W+1)'(TURN_CD));
        end else begin
            phase = ANGLE_W'(phase_sum);
        end
        n_num = NUM_W'(NUM_W'(phase) * NUM_W'(COS_STEPS)) + NUM_W'(HALF_TURN_CD);
    end

    // Quotient estimate by reciprocal; low by at most one
    assign ph_prod = PH_PROD_W'(r_num) * PH_PROD_W'(PH_RECIP);

    // Correct the estimate and wrap a full turn to step zero
    always_comb begin
        ph_rem = r_num_d - NUM_W'(r_q0 * NUM_W'(TURN_CD));
        if (ph_rem >= NUM_W'(TURN_CD)) begin
            q_fix = r_q0 + Q_W'(1);
        end else begin
            q_fix = r_q0;
        end
        if (q_fix >= Q_W'(COS_STEPS)) begin
            n_idx = '0;
        end else begin
            n_idx = IDX_W'(q_fix);
        end
    end

    // Quadrant split and mirrored table address
    always_comb begin
        if (r_idx >= IDX_W'(3 * COS_TABLE_DEPTH)) begin
            quad      = 2'd3;
            quad_base = IDX_W'(3 * COS_TABLE_DEPTH);
        end else if (r_idx >= IDX_W'(2 * COS_TABLE_DEPTH)) begin
            quad      = 2'd2;
            quad_base = IDX_W'(2 * COS_TABLE_DEPTH);
        end else if (r_idx >= IDX_W'(COS_TABLE_DEPTH)) begin
            quad      = 2'd1;
            quad_base = IDX_W'(COS_TABLE_DEPTH);
        end else begin
            quad      = 2'd0;
            quad_base = '0;
        end
        step_in_quad = R_W'(r_idx - quad_base);
        if (quad[0]) begin
            rom_addr = ADDR_W'(COS_TABLE_DEPTH) - ADDR_W'(step_in_quad);
        end else begin
            rom_addr = ADDR_W'(step_in_quad);
        end
        n_cos_neg = quad[0] ^ quad[1];
    end

    ttacl_cos_rom u_cos_rom (
        .i_clk  (i_clk),
        .i_en   (i_ctl.adv[ST_COS]),
        .i_addr (rom_addr),
        .o_data (cos_mag)
    );

    // Wide product split in two, then summed with the rounding offset
    assign bend_sum = (T_W'(r_part_hi) << SPLIT) + T_W'(r_part_lo) + BEND_RND;

    // Divide by the odd part of the scale: reciprocal estimate, then fix-up
    assign bend_prod = BPROD_W'(r_u) * BPROD_W'(BEND_RECIP);

    always_comb begin
        bend_rem = r_u_d - U_W'(r_q0b * U_W'(SCALE_ODD));
        if (bend_rem >= U_W'(SCALE_ODD)) begin
            n_bend = r_q0b + BEND_W'(1);
        end else begin
            n_bend = r_q0b;
        end
    end

    // Length with clamp to the output range
    always_comb begin
        if (r_sign[ST_BEND]) begin
            len_calc = LEN_CALC_W'(i_arm_length) + LEN_CALC_W'(r_bend);
        end else begin
            len_calc = LEN_CALC_W'(i_arm_length) - LEN_CALC_W'(r_bend);
        end
        if (len_calc[LEN_CALC_W-1]) begin
            n_length = '0;
        end else if (len_calc[LEN_CALC_W-2:LEN_W] != '0) begin
            n_length = '1;
        end else begin
            n_length = len_calc[LEN_W-1:0];
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[ST_NUM]) begin
            r_num <= n_num;
        end
        if (i_ctl.adv[ST_QEST]) begin
            r_num_d <= r_num;
            r_q0    <= ph_prod[NUM_W +: Q_W];
        end
        if (i_ctl.adv[ST_IDX]) begin
            r_idx <= n_idx;
        end
        if (i_ctl.adv[ST_COS]) begin
            r_cos_neg <= n_cos_neg;
        end
        if (i_ctl.adv[ST_MAG]) begin
            r_mag          <= MAG_W'(i_ib_prod) * MAG_W'(cos_mag);
            r_sign[ST_MAG] <= i_incl_neg ^ r_cos_neg;
        end
        if (i_ctl.adv[ST_PART]) begin
            r_part_lo       <= PART_W'(r_mag[SPLIT-1:0]) * PART_W'(PI_Q30);
            r_part_hi       <= PART_W'(r_mag[MAG_W-1:SPLIT]) * PART_W'(PI_Q30);
            r_sign[ST_PART] <= r_sign[ST_MAG];
        end
        if (i_ctl.adv[ST_SUM]) begin
            r_u            <= bend_sum[BEND_SHIFT +: U_W];
            r_sign[ST_SUM] <= r_sign[ST_PART];
        end
        if (i_ctl.adv[ST_BEST]) begin
            r_u_d           <= r_u;
            r_q0b           <= bend_prod[U_W +: BEND_W];
            r_sign[ST_BEST] <= r_sign[ST_SUM];
        end
        if (i_ctl.adv[ST_BEND]) begin
            r_bend          <= n_bend;
            r_sign[ST_BEND] <= r_sign[ST_BEST];
        end
        if (i_ctl.adv[ST_OUT]) begin
            r_length <= n_length;
            r_spool  <= SPOOL_W'(i_rest_length) - SPOOL_W'(n_length);
        end
    end

    assign o_length = r_length;
    assign o_spool  = r_spool;

endmodule

// ===== rtl/three_tendon_arm_cable_lengths_top.sv =====
`timescale 1ns / 1ps
// Tendon lengths of a three-tendon constant-curvature arm.
// Input stream (s_axis): one pose request per beat, tdata = inclination
// (signed, 0.01 deg) and orientation (0.01 deg). Output stream (m_axis):
// one result per request, three tendon lengths and three spool
// displacements in micrometres, in request order.
// Configuration: i_cfg_wr_en writes i_cfg_wdata into the register picked
// by i_cfg_index (arm length, base offset, rest length); write only while
// the pipeline is empty.
// Pipeline: eleven register stages (input, phase, step estimate, step
// fix-up, table read, two multiply stages, sum, two constant division
// stages, clamp).
// Throughput: one request per cycle while m_axis_tready is high; every stage
// is a register with its own valid bit, so a new request enters each cycle.
// Stall: when m_axis_tready is low the last stage holds its result; the
// stages behind it keep filling empty slots, and s_axis_tready drops only
// once every stage is full. Nothing is lost or repeated.
// Reset (synchronous, active low): all stages empty, registers back to
// 200000 / 35000 / 200000 um.

module three_tendon_arm_cable_lengths_top
    import ttacl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [15:0] inclination, [31:16] orientation
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [20:0] length_a, [41:21] length_b, [62:42] length_c,
    // [84:63] spool_a, [106:85] spool_b, [128:107] spool_c, [135:129] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_pipe_ctl          ctl;
    logic [ARM_W-1:0]   r_arm_length;
    logic [BASE_W-1:0]  r_base_offset;
    logic [REST_W-1:0]  r_rest_length;
    logic [INCL_W-1:0]  in_incl;
    logic [ANGLE_W-1:0] in_orient;
    logic [ANGLE_W-1:0] n_orient;
    logic [INCL_W-1:0]  n_incl_mag;
    logic [ANGLE_W-1:0] r_orient;
    logic [INCL_W-1:0]  r_incl_mag;
    logic               r_incl_neg [ST_IN:ST_COS];
    logic [IB_W-1:0]    r_ib_prod [ST_NUM:ST_COS];
    logic [LEN_W-1:0]   w_length [NUM_TENDONS];
    logic [SPOOL_W-1:0] w_spool [NUM_TENDONS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_length  <= ARM_LENGTH_RST;
            r_base_offset <= BASE_OFFSET_RST;
            r_rest_length <= REST_LENGTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ARM_LENGTH:  r_arm_length  <= ARM_W'(i_cfg_wdata);
                CFG_BASE_OFFSET: r_base_offset <= BASE_W'(i_cfg_wdata);
                CFG_REST_LENGTH: r_rest_length <= REST_W'(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    ttacl_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_ctl       (ctl)
    );

    // Input stage: orientation into one turn, inclination to sign and magnitude
    assign in_incl   = i_s_axis_tdata[INCL_W-1:0];
    assign in_orient = i_s_axis_tdata[INCL_W +: ANGLE_W];

    always_comb begin
        if (in_orient >= ANGLE_W'(TURN_CD)) begin
            n_orient = in_orient - ANGLE_W'(TURN_CD);
        end else begin
            n_orient = in_orient;
        end
        if (in_incl[INCL_W-1]) begin
            n_incl_mag = ~in_incl + INCL_W'(1);
        end else begin
            n_incl_mag = in_incl;
        end
    end

    // Shared terms: inclination times base offset, carried to the multiply stage
    always_ff @(posedge i_clk) begin
        if (ctl.adv[ST_IN]) begin
            r_orient          <= n_orient;
            r_incl_mag        <= n_incl_mag;
            r_incl_neg[ST_IN] <= in_incl[INCL_W-1];
        end
        if (ctl.adv[ST_NUM]) begin
            r_ib_prod[ST_NUM]  <= IB_W'(r_incl_mag) * IB_W'(r_base_offset);
            r_incl_neg[ST_NUM] <= r_incl_neg[ST_IN];
        end
        for (int k = ST_QEST; k <= ST_COS; k++) begin
            if (ctl.adv[k]) begin
                r_ib_prod[k]  <= r_ib_prod[k-1];
                r_incl_neg[k] <= r_incl_neg[k-1];
            end
        end
    end

    // One lane per tendon
    for (genvar g = 0; g < NUM_TENDONS; g++) begin : g_lane
        ttacl_lane u_lane (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_offset_cd   (ANGLE_W'(TENDON_OFFSET_CD[g])),
            .i_orient      (r_orient),
            .i_incl_neg    (r_incl_neg[ST_COS]),
            .i_ib_prod     (r_ib_prod[ST_COS]),
            .i_arm_length  (r_arm_length),
            .i_rest_length (r_rest_length),
            .o_length      (w_length[g]),
            .o_spool       (w_spool[g])
        );
    end

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}},
                             w_spool[2], w_spool[1], w_spool[0],
                             w_length[2], w_length[1], w_length[0]};

endmodule
